// File: hw/rtl/bsctc_pkg.sv
package bsctc_pkg;

    // Operation codes carried on the mode field
    localparam logic [1:0] MODE_TEST  = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_COUNT = 2'd3;

    // Field and index widths
    localparam int MODE_W  = 2;
    localparam int IDENT_W = 16;
    localparam int LIMIT_W = 17;
    localparam int BYTE_W  = 14;   // byte index of any identifier below 2**LIMIT_W

    // Count walks from identifier 10000, which is byte 1250, bit 0
    localparam logic [LIMIT_W-1:0] COUNT_START = 17'd10000;
    localparam logic [BYTE_W-1:0]  START_BYTE  = 14'd1250;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

    // One result word
    typedef struct packed {
        logic               done;
        logic               bit_value;
        logic [LIMIT_W-1:0] set_count;
    } t_result;

    // Number of ones in a byte
    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'd0, b[k]};
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/bsctc_mem.sv
module bsctc_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write one byte, read one byte with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bsctc_seq.sv
module bsctc_seq #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bsctc_pkg::MODE_W-1:0]      i_mode,
    input  logic [bsctc_pkg::IDENT_W-1:0]     i_ident,
    input  logic [bsctc_pkg::LIMIT_W-1:0]     i_eff_limit,
    output logic                              o_busy,
    output bsctc_pkg::t_result                o_res,
    output logic                              o_we,
    output logic [AW-1:0]                     o_waddr,
    output logic [7:0]                        o_wdata,
    output logic [AW-1:0]                     o_raddr,
    input  logic [7:0]                        i_rdata
);
    import bsctc_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_RMW    = 5'b00100,
        S_COUNT  = 5'b01000,
        S_CDRAIN = 5'b10000
    } t_state;

    t_state              r_state;
    logic [BYTE_W-1:0]   r_addr;
    logic [2:0]          r_bitpos;
    logic [MODE_W-1:0]   r_mode;
    logic                r_inrange;
    logic                r_rvld;
    logic [7:0]          r_rmask;
    logic [LIMIT_W-1:0]  r_acc;
    t_result             r_res;

    logic                accept;
    logic                in_range;
    logic [BYTE_W-1:0]   ident_byte;
    logic [BYTE_W-1:0]   rd_byte;
    logic [LIMIT_W-1:0]  lim_m1;
    logic [BYTE_W-1:0]   last_byte;
    logic [7:0]          last_mask;
    logic [7:0]          bit_mask;
    logic [7:0]          n_byte;
    logic [LIMIT_W-1:0]  n_acc;

    assign accept     = i_start && (r_state == S_IDLE);
    assign in_range   = {1'b0, i_ident} < i_eff_limit;
    assign ident_byte = {1'b0, i_ident[IDENT_W-1:3]};

    // Last byte of the count walk and the valid bits within it
    assign lim_m1    = i_eff_limit - 17'd1;
    assign last_byte = lim_m1[LIMIT_W-1:3];
    assign last_mask = 8'hFF >> (3'd7 - lim_m1[2:0]);

    // Modify the byte just read
    assign bit_mask = 8'd1 << r_bitpos;
    always_comb begin
        case (r_mode)
            MODE_SET:   n_byte = i_rdata | bit_mask;
            MODE_CLEAR: n_byte = i_rdata & ~bit_mask;
            default:    n_byte = i_rdata;
        endcase
    end

    // Running count including the byte arriving this cycle
    assign n_acc = r_rvld ? r_acc + {13'd0, pop8(i_rdata & r_rmask)} : r_acc;

    // Memory port selection
    assign rd_byte = (r_state == S_COUNT) ? r_addr : ident_byte;
    assign o_raddr = rd_byte[AW-1:0];
    assign o_waddr = (r_state == S_CLEAR) ? r_addr[AW-1:0] : r_addr[AW-1:0];
    assign o_wdata = (r_state == S_CLEAR) ? 8'd0 : n_byte;
    assign o_we    = (r_state == S_CLEAR) ||
                     ((r_state == S_RMW) && r_inrange &&
                      ((r_mode == MODE_SET) || (r_mode == MODE_CLEAR)));

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_rvld    <= 1'b0;
            r_res     <= '0;
        end else begin
            r_rvld <= (r_state == S_COUNT);
            case (r_state)
                S_CLEAR: begin
                    r_res.done <= 1'b0;
                    if (r_addr == BYTE_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 14'd1;
                    end
                end
                S_IDLE: begin
                    if (accept && (i_mode == MODE_COUNT) && (i_eff_limit <= COUNT_START)) begin
                        r_res <= '{done: 1'b1, bit_value: 1'b0, set_count: '0};
                    end else begin
                        r_res.done <= 1'b0;
                    end
                    if (accept) begin
                        if (i_mode == MODE_COUNT) begin
                            r_acc  <= '0;
                            r_addr <= START_BYTE;
                            if (i_eff_limit > COUNT_START) begin
                                r_state <= S_COUNT;
                            end
                        end else begin
                            r_addr    <= ident_byte;
                            r_bitpos  <= i_ident[2:0];
                            r_mode    <= i_mode;
                            r_inrange <= in_range;
                            r_state   <= S_RMW;
                        end
                    end
                end
                S_RMW: begin
                    r_res   <= '{done: 1'b1, bit_value: r_inrange & n_byte[r_bitpos],
                                 set_count: '0};
                    r_state <= S_IDLE;
                end
                S_COUNT: begin
                    r_res.done <= 1'b0;
                    r_acc      <= n_acc;
                    r_rmask    <= (r_addr == last_byte) ? last_mask : 8'hFF;
                    if (r_addr == last_byte) begin
                        r_state <= S_CDRAIN;
                    end else begin
                        r_addr <= r_addr + 14'd1;
                    end
                end
                S_CDRAIN: begin
                    r_res   <= '{done: 1'b1, bit_value: 1'b0, set_count: n_acc};
                    r_state <= S_IDLE;
                end
                default: begin
                    r_res.done <= 1'b0;
                    r_state    <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;

endmodule

// File: hw/rtl/bitmap_set_clear_test_count_core.sv
// Status bitmap: one bit per identifier, held in a byte-wide single-port-read
// memory (identifier i sits in byte i/8, bit i%8).
//
// Command channel: start with mode and ident; a word is taken at a clock edge
// where start is high and busy is low. Modes: test, set, clear, count.
// Result channel: o_done is high for one cycle with o_bit_value and
// o_set_count; the receiver takes every result and cannot stall the block.
// Configuration: i_cfg_valid/o_cfg_ready carry id_limit; ready is always high.
//
// Test, set and clear do one read-modify-write of the addressed byte in the
// RMW state, which registers the result and returns to idle, where the next
// command can be taken. Out-of-range identifiers (at or above the smaller
// of id_limit and MAP_BITS) return 0 and leave the map alone.
// Count walks the memory read port one byte per cycle from identifier 10000 up
// to the limit, then registers the total in a drain state; a limit of 10000 or
// less returns 0 in the cycle after the command is taken.
// After reset the block sweeps the min((MAP_BITS+7)/8, 16384) memory bytes to
// zero, one byte per cycle, holding busy high until the sweep ends;
// configuration writes are taken throughout.
module bitmap_set_clear_test_count_core #(
    parameter longint MAP_BITS = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bsctc_pkg::MODE_W-1:0]      i_mode,
    input  logic [bsctc_pkg::IDENT_W-1:0]     i_ident,
    output logic                              o_done,
    output logic                              o_bit_value,
    output logic [bsctc_pkg::LIMIT_W-1:0]     o_set_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bsctc_pkg::LIMIT_W-1:0]     i_cfg_data
);
    import bsctc_pkg::*;

    localparam longint STORE_BYTES = (MAP_BITS + 7) / 8;
    localparam int     DEPTH       = (STORE_BYTES > 16384) ? 16384 : int'(STORE_BYTES);
    localparam int     AW          = $clog2(DEPTH);
    localparam logic [LIMIT_W-1:0] LIM_CAP =
        (MAP_BITS > 131071) ? 17'h1FFFF : LIMIT_W'(MAP_BITS);

    logic [LIMIT_W-1:0] r_id_limit;
    logic [LIMIT_W-1:0] eff_limit;
    t_result            res;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [7:0]         wdata;
    logic [AW-1:0]      raddr;
    logic [7:0]         rdata;

    // Hold the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_id_limit <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Clamp the limit to the map size
    assign eff_limit = (r_id_limit > LIM_CAP) ? LIM_CAP : r_id_limit;

    bsctc_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_ident     (i_ident),
        .i_eff_limit (eff_limit),
        .o_busy      (busy),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    bsctc_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_done      = res.done;
    assign o_bit_value = res.bit_value;
    assign o_set_count = res.set_count;

    // A bit command keeps the block busy for its write-back cycle
    a_bit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode != MODE_COUNT)) |=> busy)
        else $error("bit command did not enter read-modify-write");

    // A set of an in-range identifier reports the bit as one
    a_set_reads_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_SET) && ({1'b0, i_ident} < eff_limit))
        |-> ##2 (o_done && o_bit_value))
        else $error("set did not return one");

    // A clear of any identifier reports zero
    a_clear_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_CLEAR)) |-> ##2 (o_done && !o_bit_value))
        else $error("clear did not return zero");

    // Count and bit results never mix
    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_set_count != '0)) |-> !o_bit_value)
        else $error("result carries both a bit and a count");

endmodule

// File: test/tb_bitmap_set_clear_test_count_core.sv
module tb_bitmap_set_clear_test_count_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bsctc_pkg::*;

    localparam int unsigned MAP_SIZE = 65536;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IDENT_W-1:0] ident;
    } t_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [MODE_W-1:0]    i_mode = '0;
    logic [IDENT_W-1:0]   i_ident = '0;
    logic                 o_done;
    logic                 o_bit_value;
    logic [LIMIT_W-1:0]   o_set_count;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LIMIT_W-1:0]   i_cfg_data = '0;

    // Mirror of the status map and the limit register
    logic [7:0]           map_bytes [0:8191];
    logic [LIMIT_W-1:0]   limit_reg = LIMIT_RESET;

    t_cmd                 pending_cmds [$];
    t_result              awaited_results [$];
    int unsigned          idle_pct = 0;
    int unsigned          hot_ids [8];

    int                   cmds_accepted = 0;
    int                   counts_accepted = 0;
    int                   beyond_limit = 0;
    int                   results_checked = 0;
    int                   mismatch_count = 0;
    int                   settings_used = 1;

    logic [LIMIT_W-1:0]   phase_limits [9] = '{17'd65536, 17'd20000, 17'd1, 17'd65535,
                                               17'd12345, 17'h1FFFF, 17'd10001, 17'd40000,
                                               17'd65536};

    bitmap_set_clear_test_count_core #(
        .MAP_BITS(MAP_SIZE)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_mode(i_mode),
        .i_ident(i_ident),
        .o_done(o_done),
        .o_bit_value(o_bit_value),
        .o_set_count(o_set_count),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Clamp the limit register to the map size
    function automatic int unsigned eff_limit();
        int unsigned lim;
        lim = 32'(limit_reg);
        return (lim > MAP_SIZE) ? MAP_SIZE : lim;
    endfunction

    // Apply one command to the mirror map and return the word it should produce
    function automatic t_result apply_command(input t_cmd c);
        t_result     r;
        int unsigned lim;
        int unsigned n;
        r = '0;
        r.done = 1'b1;
        lim = eff_limit();
        n = 0;
        cmds_accepted++;
        if (c.mode == MODE_COUNT) begin
            counts_accepted++;
            for (int unsigned id = 32'(COUNT_START); id < lim; id++) begin
                n += 32'(map_bytes[id[15:3]][id[2:0]]);
            end
            r.set_count = n[LIMIT_W-1:0];
        end else if (32'(c.ident) < lim) begin
            case (c.mode)
                MODE_SET:   map_bytes[c.ident[15:3]][c.ident[2:0]] = 1'b1;
                MODE_CLEAR: map_bytes[c.ident[15:3]][c.ident[2:0]] = 1'b0;
                default: ;
            endcase
            r.bit_value = map_bytes[c.ident[15:3]][c.ident[2:0]];
        end else begin
            beyond_limit++;
        end
        return r;
    endfunction

    task automatic note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // Take a word when start meets a free block; then present the next one or idle
    always @(posedge i_clk) begin
        logic holding;
        holding = start && busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                awaited_results.push_back(apply_command(pending_cmds[0]));
                void'(pending_cmds.pop_front());
            end
            if (!holding) begin
                if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
                    start   <= 1'b1;
                    i_mode  <= pending_cmds[0].mode;
                    i_ident <= pending_cmds[0].ident;
                end else begin
                    start   <= 1'b0;
                    i_mode  <= MODE_W'($urandom);
                    i_ident <= IDENT_W'($urandom);
                end
            end
        end
    end

    // Check every result word against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            results_checked++;
            if (awaited_results.size() == 0) begin
                note_failure($sformatf("result with nothing pending: bit %0b count %0d",
                                       o_bit_value, o_set_count));
            end else begin
                want = awaited_results.pop_front();
                if (o_bit_value !== want.bit_value || o_set_count !== want.set_count) begin
                    note_failure($sformatf("expected bit %0b count %0d, got bit %0b count %0d",
                                           want.bit_value, want.set_count,
                                           o_bit_value, o_set_count));
                end
            end
        end
    end

    task automatic push_cmd(input logic [MODE_W-1:0] m, input int unsigned id);
        t_cmd c;
        c.mode  = m;
        c.ident = id[IDENT_W-1:0];
        pending_cmds.push_back(c);
    endtask

    // Hold off until every word is taken and every result is back
    task automatic settle();
        while (pending_cmds.size() != 0 || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        limit_reg = v;
        settings_used++;
    endtask

    task automatic next_setting(input logic [LIMIT_W-1:0] v, input int unsigned idle);
        settle();
        write_limit(v);
        idle_pct = idle;
    endtask

    // Favor identifiers near the limit, inside the count window and a few reused ones
    function automatic int unsigned pick_ident();
        int unsigned lim;
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        lim = eff_limit();
        r = $urandom_range(99, 0);
        if (r < 25) begin
            return $urandom_range(65535, 0);
        end
        if (r < 45) begin
            lo = (lim >= 2) ? lim - 2 : 0;
            hi = (lim < 65535) ? lim + 1 : 65535;
            return $urandom_range(hi, lo);
        end
        if (r < 75 && lim > 32'(COUNT_START)) begin
            return $urandom_range(lim - 1, 32'(COUNT_START));
        end
        if (r < 75 && lim > 0) begin
            return $urandom_range(lim - 1, 0);
        end
        return hot_ids[$urandom_range(7, 0)];
    endfunction

    task automatic queue_random(input int n);
        int unsigned r;
        int unsigned cnt_pct;
        logic [MODE_W-1:0] m;
        cnt_pct = (eff_limit() > 30000) ? 2 : 12;
        for (int k = 0; k < 8; k++) begin
            hot_ids[k] = pick_ident();
        end
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99, 0);
            if (r < cnt_pct) begin
                m = MODE_COUNT;
            end else if (r < cnt_pct + 40) begin
                m = MODE_SET;
            end else if (r < cnt_pct + 65) begin
                m = MODE_CLEAR;
            end else begin
                m = MODE_TEST;
            end
            push_cmd(m, pick_ident());
        end
    endtask

    initial begin
        foreach (map_bytes[k]) map_bytes[k] = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Edges of the map at the reset limit
        push_cmd(MODE_COUNT, 0);
        push_cmd(MODE_TEST, 0);
        push_cmd(MODE_TEST, 65535);
        push_cmd(MODE_SET, 0);
        push_cmd(MODE_SET, 65535);
        push_cmd(MODE_SET, 10000);
        push_cmd(MODE_SET, 9999);
        push_cmd(MODE_SET, 16'hAAAA);
        push_cmd(MODE_SET, 16'h5555);
        push_cmd(MODE_COUNT, 65535);
        push_cmd(MODE_CLEAR, 65535);
        push_cmd(MODE_TEST, 65535);
        push_cmd(MODE_CLEAR, 0);
        push_cmd(MODE_TEST, 0);

        // Zero limit: everything out of range, count empty
        next_setting(17'd0, 0);
        push_cmd(MODE_TEST, 10000);
        push_cmd(MODE_SET, 100);
        push_cmd(MODE_COUNT, 0);

        // Limit at the count start
        next_setting(17'd10000, 0);
        push_cmd(MODE_COUNT, 0);
        push_cmd(MODE_SET, 9999);
        push_cmd(MODE_CLEAR, 10000);

        // One identifier in the count window
        next_setting(17'd10001, 0);
        push_cmd(MODE_TEST, 10000);
        push_cmd(MODE_COUNT, 0);

        // Limit above the map size
        next_setting(17'h1FFFF, 0);
        push_cmd(MODE_SET, 65535);
        push_cmd(MODE_COUNT, 0);

        // Random phases over several limits and sender idle rates
        for (int p = 0; p < 9; p++) begin
            next_setting(phase_limits[p], (p % 3 == 1) ? 64 : ((p % 3 == 2) ? 23 : 0));
            queue_random(114);
        end

        settle();
        repeat (16) @(posedge i_clk);
        $display("tb: %0d commands over %0d limit settings, %0d population counts,",
                 cmds_accepted, settings_used, counts_accepted);
        $display("tb: %0d beyond the limit, %0d results checked, %0d mismatches",
                 beyond_limit, results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_bitmap_set_clear_test_count_core: PASS");
        end else begin
            $display("tb_bitmap_set_clear_test_count_core: FAIL");
        end
        $finish;
    end

    // Drop the run if it hangs
    initial begin
        #40_000_000;
        $display("tb_bitmap_set_clear_test_count_core: FAIL");
        $finish;
    end

endmodule
